// ===== rtl/dedup_window_byte_budget_macros.svh =====
// Assertion macros shared by the dedup window RTL.
`ifndef DEDUP_WINDOW_BYTE_BUDGET_MACROS_SVH
`define DEDUP_WINDOW_BYTE_BUDGET_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define DWB_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Checks that a condition leads to a consequence in the next cycle.
`define DWB_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/dwb_pkg.sv =====
package dwb_pkg;

   // Mixing constants of the home slot hash.
   localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_A  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_B  = 64'h94d049bb133111eb;

   localparam int WINDOW_W = 39;
   localparam int TALLY_W  = 32;
   localparam int BUDGET_W = 40;

   localparam logic OP_END     = 1'b0;
   localparam logic OP_RECYCLE = 1'b1;

   // Start and seed of a request to the hash unit.
   typedef struct packed {
      logic start;
      logic [63:0] seed;
   } hash_req_type;

endpackage

// ===== rtl/dedup_window_byte_budget.sv =====
// Channel   Direction  Handshake                 Payload
// req       in         start high, busy low      opcode, flags, digest, size
// rsp       out        rsp_valid strobe          flags, window, tallies
// csr       in         csr_valid and csr_ready   byte_limit
// A tracked transaction passes through the seed, hash, probe, decision and
// output states in that order; the hash runs on the shared 32x32 multiplier,
// and each probe is one registered RAM read and one compare, repeated for each
// occupied slot probed. Other transactions skip the hash and the probes.
// The set holds 3/4 of the slots, so a probe chain reads at most
// TABLE_SLOTS*3/4+1 slots; TABLE_SLOTS is a power of two. Reset is synchronous
// and clears the sequencer, budget, window and tallies at once. The result
// cannot be stalled; busy stays high from accept until the strobe ends.
`include "dedup_window_byte_budget_macros.svh"

module dedup_window_byte_budget #(
   parameter int TABLE_SLOTS = 64,
   parameter int SIZE_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic        req_process_changed,
   input  logic        req_process_running,
   input  logic        req_has_source,
   input  logic [63:0] req_digest_w0,
   input  logic [63:0] req_digest_w1,
   input  logic [63:0] req_digest_w2,
   input  logic [63:0] req_digest_w3,
   input  logic [31:0] req_source_size,
   input  logic        req_recycle_ok,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic        rsp_inserted,
   output logic        rsp_tracking_failed,
   output logic        rsp_recycle_request,
   output logic        rsp_window_cleared,
   output logic [37:0] rsp_window_bytes,
   output logic [6:0]  rsp_entry_count,
   output logic [37:0] rsp_peak_bytes,
   output logic [31:0] rsp_failure_count,
   output logic [31:0] rsp_budget_recycle_count,
   output logic [31:0] rsp_scan_count,
   output logic [31:0] rsp_unique_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [39:0] csr_byte_limit
);

   localparam int AW         = $clog2(TABLE_SLOTS);
   localparam int CW         = $clog2(TABLE_SLOTS + 1);
   localparam int LOAD_LIMIT = TABLE_SLOTS - TABLE_SLOTS / 4;
   localparam int SLOT_W     = 4 * 64 + SIZE_BITS;
   localparam int WW         = dwb_pkg::WINDOW_W;
   localparam int TW         = dwb_pkg::TALLY_W;
   localparam logic [WW-1:0] WINDOW_MAX = {WW{1'b1}};
   localparam logic [TW-1:0] TALLY_MAX  = {TW{1'b1}};

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SEED = 3'd1;
   localparam logic [2:0] S_HASH = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_CMP  = 3'd4;
   localparam logic [2:0] S_DEC  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [dwb_pkg::BUDGET_W-1:0] budget_ff;
   logic                   opcode_ff, changed_ff, running_ff, has_src_ff, rec_ok_ff;
   logic [63:0]            w0_ff, w1_ff, w2_ff, w3_ff;
   logic [SIZE_BITS-1:0]   size_ff;
   logic [AW-1:0]          slot_ff, slot_in;
   logic [CW-1:0]          probes_ff, probes_in;
   logic                   hit_ff, hit_in;
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [CW-1:0]          live_ff;
   logic [WW-1:0]          total_ff, peak_ff;
   logic [TW-1:0]          fail_ff, brec_ff, scan_ff, uniq_ff;
   logic                   o_hit_ff, o_ins_ff, o_fail_ff, o_req_ff, o_clr_ff;
   logic                   hash_done;
   logic [63:0]            hash_val;
   dwb_pkg::hash_req_type  hreq;
   logic [SLOT_W-1:0]      rd_data, wr_data;
   logic                   wr_en;
   logic                   match;
   logic [WW-1:0]          size_ext, new_total;
   logic                   tracking, load_full, overflow;
   logic [63:0]            seed_mix;

   // Hash unit and slot store; the hash runs only for a lookup.
   assign hreq.start = (state_ff == S_SEED) && tracking;
   assign hreq.seed  = seed_mix;

   dwb_hash u_hash (
      .clock (clock),
      .reset (reset),
      .req   (hreq),
      .done  (hash_done),
      .hash  (hash_val)
   );

   dwb_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_data),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   assign wr_data = {w0_ff, w1_ff, w2_ff, w3_ff, size_ff};
   assign match   = (rd_data == wr_data);
   assign wr_en   = (state_ff == S_DEC) && tracking && !hit_ff && !load_full && !overflow;

   assign seed_mix = w0_ff ^ ({{(64-SIZE_BITS){1'b0}}, size_ff} + dwb_pkg::GOLDEN
                     + (w0_ff << 6) + (w0_ff >> 2));

   assign tracking  = (opcode_ff == dwb_pkg::OP_END) && (budget_ff != '0) && has_src_ff;
   assign size_ext  = WW'(size_ff);
   assign new_total = total_ff + size_ext;
   assign load_full = (live_ff + CW'(1)) > CW'(LOAD_LIMIT);
   assign overflow  = size_ext > (WINDOW_MAX - total_ff);

   // Sequencer: hash, then probe until a free slot or a match.
   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      probes_in = probes_ff;
      hit_in    = hit_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_SEED;
         S_SEED: state_in = tracking ? S_HASH : S_DEC;
         S_HASH: begin
            hit_in    = 1'b0;
            probes_in = '0;
            if (hash_done) begin
               slot_in  = hash_val[AW-1:0];
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (!valid_ff[slot_ff] || probes_ff == CW'(TABLE_SLOTS)) begin
               state_in = S_DEC;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (match) begin
               hit_in   = 1'b1;
               state_in = S_DEC;
            end else begin
               slot_in   = (slot_ff == AW'(TABLE_SLOTS - 1)) ? '0 : slot_ff + AW'(1);
               probes_in = probes_ff + CW'(1);
               state_in  = S_RD;
            end
         end
         S_DEC: state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Decision and window bookkeeping.
   always_ff @(posedge clock) begin
      logic                   clr;
      logic                   ins, fl, rq;
      logic [CW-1:0]          live_n;
      logic [WW-1:0]          tot_n;
      logic [TW-1:0]          fail_n, brec_n;
      logic [TABLE_SLOTS-1:0] valid_n;
      if (reset) begin
         state_ff  <= S_IDLE;
         budget_ff <= '0;
         valid_ff  <= '0;
         live_ff   <= '0;
         total_ff  <= '0;
         peak_ff   <= '0;
         fail_ff   <= '0;
         brec_ff   <= '0;
         scan_ff   <= '0;
         uniq_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            budget_ff <= csr_byte_limit;
         end
         if (state_ff == S_SEED && changed_ff && opcode_ff == dwb_pkg::OP_END) begin
            valid_ff <= '0;
            live_ff  <= '0;
            total_ff <= '0;
         end
         if (state_ff == S_SEED && tracking && scan_ff != TALLY_MAX) begin
            scan_ff <= scan_ff + TW'(1);
         end
         if (state_ff == S_DEC) begin
            clr     = 1'b0;
            ins     = wr_en;
            fl      = tracking && !hit_ff && (load_full || overflow);
            rq      = (opcode_ff == dwb_pkg::OP_RECYCLE);
            live_n  = live_ff;
            tot_n   = total_ff;
            fail_n  = fail_ff;
            brec_n  = brec_ff;
            valid_n = valid_ff;
            if (ins) begin
               live_n = live_ff + CW'(1);
               tot_n  = new_total;
               valid_n[slot_ff] = 1'b1;
               if (new_total > peak_ff) peak_ff <= new_total;
               if (uniq_ff != TALLY_MAX) uniq_ff <= uniq_ff + TW'(1);
            end
            if (opcode_ff == dwb_pkg::OP_RECYCLE) begin
               clr = rec_ok_ff;
            end else if (fl) begin
               if (fail_n != TALLY_MAX) fail_n = fail_n + TW'(1);
               if (running_ff) begin
                  rq = 1'b1;
                  if (rec_ok_ff) begin
                     clr = 1'b1;
                     if (brec_n != TALLY_MAX) brec_n = brec_n + TW'(1);
                  end
               end else begin
                  clr = 1'b1;
               end
            end else if (running_ff && budget_ff != '0 && live_n > CW'(1)
                         && {1'b0, tot_n} > budget_ff) begin
               rq = 1'b1;
               if (rec_ok_ff) begin
                  clr = 1'b1;
                  if (brec_n != TALLY_MAX) brec_n = brec_n + TW'(1);
               end else if (fail_n != TALLY_MAX) begin
                  fail_n = fail_n + TW'(1);
               end
            end
            if (clr) begin
               valid_n = '0;
               live_n  = '0;
               tot_n   = '0;
            end
            valid_ff  <= valid_n;
            live_ff   <= live_n;
            total_ff  <= tot_n;
            fail_ff   <= fail_n;
            brec_ff   <= brec_n;
            o_hit_ff  <= hit_ff && tracking;
            o_ins_ff  <= ins;
            o_fail_ff <= fl;
            o_req_ff  <= rq;
            o_clr_ff  <= clr || (changed_ff && opcode_ff == dwb_pkg::OP_END);
         end
      end
   end

   // Captured item and probe registers.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         opcode_ff  <= req_opcode;
         changed_ff <= req_process_changed;
         running_ff <= req_process_running;
         has_src_ff <= req_has_source;
         w0_ff      <= req_digest_w0;
         w1_ff      <= req_digest_w1;
         w2_ff      <= req_digest_w2;
         w3_ff      <= req_digest_w3;
         size_ff    <= SIZE_BITS'(req_source_size);
         rec_ok_ff  <= req_recycle_ok;
      end
      if (state_ff == S_SEED) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      slot_ff   <= slot_in;
      probes_ff <= probes_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_hit             = o_hit_ff;
   assign rsp_inserted        = o_ins_ff;
   assign rsp_tracking_failed = o_fail_ff;
   assign rsp_recycle_request = o_req_ff;
   assign rsp_window_cleared  = o_clr_ff;
   assign rsp_window_bytes    = total_ff[37:0];
   assign rsp_entry_count     = 7'(live_ff);
   assign rsp_peak_bytes      = peak_ff[37:0];
   assign rsp_failure_count        = fail_ff;
   assign rsp_budget_recycle_count = brec_ff;
   assign rsp_scan_count           = scan_ff;
   assign rsp_unique_count         = uniq_ff;

   `DWB_ASSERT_IMP(a_live_limit, clock, reset, 1'b1, live_ff <= CW'(LOAD_LIMIT),
      "entry count above load limit")
   `DWB_ASSERT_IMP(a_live_ones, clock, reset, state_ff == S_IDLE,
      $countones(valid_ff) == int'(live_ff), "valid bits disagree with count")
   `DWB_ASSERT_IMP(a_ins_hit, clock, reset, rsp_valid, !(rsp_hit && rsp_inserted),
      "hit and insert together")
   `DWB_ASSERT_NEXT(a_rsp_strobe, clock, reset, rsp_valid, !rsp_valid && !busy,
      "result strobe longer than one cycle")

endmodule

// ===== rtl/dwb_ram.sv =====
module dwb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dwb_hash.sv =====
`include "dedup_window_byte_budget_macros.svh"

module dwb_hash (
   input  logic                clock,
   input  logic                reset,
   input  dwb_pkg::hash_req_type req,
   output logic                done,
   output logic [63:0]         hash
);

   // Steps of the shared 32x32 multiplier over the two 64-bit products.
   localparam logic [3:0] H_IDLE  = 4'd0;
   localparam logic [3:0] H_MUL1  = 4'd1;
   localparam logic [3:0] H_ADD1A = 4'd2;
   localparam logic [3:0] H_ADD1B = 4'd3;
   localparam logic [3:0] H_MIX   = 4'd4;
   localparam logic [3:0] H_MUL2  = 4'd5;
   localparam logic [3:0] H_ADD2A = 4'd6;
   localparam logic [3:0] H_ADD2B = 4'd7;
   localparam logic [3:0] H_FIN   = 4'd8;

   logic [3:0]  step_ff, step_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] k_ff, k_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] ma, mb;
   logic [63:0] prod;
   logic [63:0] mixed;

   // Partial product select within one 64x64 low-half multiply.
   always_comb begin
      unique case (step_ff[1:0])
         2'd1: begin ma = x_ff[31:0];  mb = k_ff[31:0];  end
         2'd2: begin ma = x_ff[31:0];  mb = k_ff[63:32]; end
         2'd3: begin ma = x_ff[63:32]; mb = k_ff[31:0];  end
         default: begin ma = '0; mb = '0; end
      endcase
   end
   assign prod = ma * mb;
   assign mixed = acc_ff ^ (acc_ff >> ((step_ff == H_MIX) ? 27 : 31));

   // Sequencer: per multiply, three partial products and an xor-shift.
   always_comb begin
      step_in = step_ff;
      x_in    = x_ff;
      k_in    = k_ff;
      acc_in  = acc_ff;
      unique case (step_ff) inside
         H_IDLE: begin
            if (req.start) begin
               x_in    = req.seed ^ (req.seed >> 30);
               k_in    = dwb_pkg::MIX_A;
               acc_in  = '0;
               step_in = H_MUL1;
            end
         end
         H_MUL1, H_MUL2: begin
            acc_in  = prod;
            step_in = step_ff + 4'd1;
         end
         H_ADD1A, H_ADD1B, H_ADD2A: begin
            acc_in  = acc_ff + {prod[31:0], 32'd0};
            step_in = step_ff + 4'd1;
         end
         H_MIX: begin
            x_in    = mixed;
            k_in    = dwb_pkg::MIX_B;
            step_in = H_MUL2;
         end
         H_ADD2B: begin
            acc_in  = acc_ff + {prod[31:0], 32'd0};
            step_in = H_FIN;
         end
         default: step_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= H_IDLE;
      end else begin
         step_ff <= step_in;
      end
      x_ff   <= x_in;
      k_ff   <= k_in;
      acc_ff <= acc_in;
   end

   assign done = (step_ff == H_FIN);
   assign hash = mixed;

   `DWB_ASSERT_NEXT(a_hash_done_once, clock, reset, done, !done, "hash done held")
   `DWB_ASSERT_IMP(a_hash_no_restart, clock, reset, req.start, step_ff == H_IDLE,
      "hash restarted while working")

endmodule
